### rtl/core/softmax_row_normalizer_macros.svh
// Assertion macros shared by the softmax row normalizer RTL.
`ifndef SOFTMAX_ROW_NORMALIZER_MACROS_SVH
`define SOFTMAX_ROW_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/smx_pkg.sv
// Shared types, constants and tables of the softmax row normalizer.
package smx_pkg;

  localparam int LOGIT_W = 16;
  localparam int EXP_W   = 32;
  localparam int SUM_W   = 38;
  localparam int PROB_W  = 16;

  // log2(e) in Q1.28 and ln(2) in Q0.32
  localparam logic [28:0] LOG2E_Q28 = 29'h1715_4765;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

  // Last Taylor term index
  localparam logic [3:0] TAYLOR_LAST = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXP, ST_RD, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } smx_state_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_LOG, EX_FRAC, EX_MUL, EX_RCP, EX_FIX, EX_OUT, EX_DONE
  } smx_exp_state_t;

  // floor(2^33 / i) for the Taylor divisors 2..11
  function automatic logic [32:0] smx_recip(input logic [3:0] idx);
    logic [32:0] r;
    unique case (idx)
      4'd2:    r = 33'd4294967296;
      4'd3:    r = 33'd2863311530;
      4'd4:    r = 33'd2147483648;
      4'd5:    r = 33'd1717986918;
      4'd6:    r = 33'd1431655765;
      4'd7:    r = 33'd1227133513;
      4'd8:    r = 33'd1073741824;
      4'd9:    r = 33'd954437176;
      4'd10:   r = 33'd858993459;
      4'd11:   r = 33'd780903144;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/smx_if.sv
// Valid/ready channel interfaces for logits and probabilities.
interface smx_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit_value;
  logic               row_end;
  modport source (output valid, logit_value, row_end, input ready);
  modport sink   (input valid, logit_value, row_end, output ready);
endinterface

interface smx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic        last_of_row;
  logic        row_overflow;
  modport source (output valid, probability, last_of_row, row_overflow, input ready);
  modport sink   (input valid, probability, last_of_row, row_overflow, output ready);
endinterface

### rtl/core/softmax_row_normalizer.sv
// Softmax row normalizer top level: row buffer, row sum, emit sequencer.
//
//   channel   | dir | handshake      | payload
//   in_ch     | in  | valid / ready  | logit_value (s16 Q4.12), row_end
//   out_ch    | out | valid / ready  | probability (u16 Q0.16), last_of_row, row_overflow
//
// After a stored logit is accepted, in_ch.ready returns only when the exponential
// unit is done (ten Taylor steps, each a multiply, reciprocal and fix-up state); a
// dropped logit leaves in_ch.ready high unless it ends the row.
// Each probability takes a buffer read, then the 16-step divider.
// One item at a time: in_ch.ready is high only while the sequencer waits for input.
// Reset is synchronous and active low; it clears the sum, count and overflow mark.
// A stalled out_ch holds the probability until it is taken.
`include "softmax_row_normalizer_macros.svh"

module softmax_row_normalizer
  import smx_pkg::*;
#(
  parameter int MAX_ROW = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int CW = $clog2(MAX_ROW + 1);

  smx_state_t state_r, state_nxt;

  logic [SUM_W-1:0] sum_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic             ovf_r;
  logic             end_r;

  logic [EXP_W-1:0] buf_mem [MAX_ROW];
  logic [EXP_W-1:0] rd_data_r;

  logic             in_acc;
  logic             out_acc;
  logic             room;
  logic             last;
  logic             exp_start;
  logic             exp_done;
  logic [EXP_W-1:0] exp_res;
  logic             div_start;
  logic             div_done;
  logic [PROB_W-1:0] div_quo;
  logic [48:0]      dividend;
  logic             rd_en;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign room     = (cnt_r < CW'(MAX_ROW));
  assign last     = ((idx_r + CW'(1)) == cnt_r);
  assign dividend = {1'b0, rd_data_r, 16'd0} + 49'(sum_r[SUM_W-1:1]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (room)               state_nxt = ST_EXP;
          else if (in_ch.row_end) state_nxt = ST_RD;
        end
      end
      ST_EXP:      if (exp_done) state_nxt = end_r ? ST_RD : ST_IDLE;
      ST_RD:       state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = ST_OUT;
      ST_OUT:      if (out_ch.ready) state_nxt = last ? ST_IDLE : ST_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ch.ready         = (state_r == ST_IDLE);
    out_ch.valid        = (state_r == ST_OUT);
    out_ch.probability  = div_quo;
    out_ch.last_of_row  = last;
    out_ch.row_overflow = ovf_r;
    rd_en               = (state_r == ST_RD);
    div_start           = (state_r == ST_DIV_GO);
    exp_start           = in_acc && room;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      end_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        end_r <= in_ch.row_end;
        idx_r <= '0;
        if (!room) ovf_r <= 1'b1;
      end
      if (state_r == ST_EXP && exp_done) begin
        sum_r <= sum_r + SUM_W'(exp_res);
        cnt_r <= cnt_r + CW'(1);
      end
      if (out_acc) begin
        if (last) begin
          sum_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
    end
  end

  // Row buffer: write on exponential done, registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_EXP && exp_done) buf_mem[cnt_r[AW-1:0]] <= exp_res;
    if (rd_en) rd_data_r <= buf_mem[idx_r[AW-1:0]];
  end

  smx_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .logit  (in_ch.logit_value),
    .done   (exp_done),
    .result (exp_res)
  );

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (sum_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  `SMX_ASSERT_NOW(a_emit_nonempty, clk, rst_n, out_ch.valid, cnt_r != '0, "emit with empty row")
  `SMX_ASSERT_NOW(a_write_in_range, clk, rst_n, state_r == ST_EXP && exp_done, room, "row buffer write past capacity")
  `SMX_ASSERT_NEXT(a_row_clears, clk, rst_n, out_acc && last, cnt_r == '0 && sum_r == '0 && !ovf_r, "row state not cleared")

endmodule

### rtl/core/smx_exp.sv
// Iterative fixed-point exponential: Q4.12 logit to saturated Q12.20.
module smx_exp
  import smx_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [LOGIT_W-1:0] logit,
  output logic                      done,
  output logic [EXP_W-1:0]          result
);

  smx_exp_state_t state_r, state_nxt;

  logic signed [LOGIT_W-1:0] logit_r;
  logic [4:0]  nb_r;
  logic [31:0] frac_r;
  logic [31:0] u_r;
  logic [31:0] term_r;
  logic [31:0] t_r;
  logic [64:0] prod_r;
  logic [33:0] sum_r;
  logic [3:0]  i_r;
  logic [EXP_W-1:0] result_r;

  logic signed [45:0] p_s;
  logic [63:0] u_prod;
  logic [63:0] t_prod;
  logic [31:0] q0;
  logic [35:0] qi;
  logic [31:0] rem;
  logic [31:0] q_fix;
  logic [4:0]  sh;
  logic [34:0] rounded;
  logic [34:0] shifted;

  // Datapath arithmetic
  always_comb begin
    p_s     = 46'(logit_r) * $signed({17'd0, LOG2E_Q28}) + (46'sd12 <<< 40);
    u_prod  = 64'(frac_r) * 64'(LN2_Q32);
    t_prod  = 64'(term_r) * 64'(u_r);
    q0      = prod_r[64:33];
    qi      = 36'(q0) * 36'(i_r);
    rem     = t_r - qi[31:0];
    q_fix   = (rem >= 32'(i_r)) ? q0 + 32'd1 : q0;
    sh      = 5'd24 - nb_r;
    rounded = {1'b0, sum_r} + (35'd1 << (sh - 5'd1));
    shifted = rounded >> sh;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EX_IDLE: if (start) state_nxt = EX_LOG;
      EX_LOG:  state_nxt = EX_FRAC;
      EX_FRAC: state_nxt = EX_MUL;
      EX_MUL:  state_nxt = EX_RCP;
      EX_RCP:  state_nxt = EX_FIX;
      EX_FIX:  state_nxt = (i_r == TAYLOR_LAST) ? EX_OUT : EX_MUL;
      EX_OUT:  state_nxt = EX_DONE;
      EX_DONE: state_nxt = EX_IDLE;
      default: state_nxt = EX_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done   = (state_r == EX_DONE);
    result = result_r;
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      EX_IDLE: if (start) logit_r <= logit;
      EX_LOG: begin
        nb_r   <= p_s[44:40];
        frac_r <= p_s[39:8];
      end
      EX_FRAC: begin
        u_r    <= u_prod[63:32];
        term_r <= u_prod[63:32];
        sum_r  <= (34'd1 << 32) + 34'(u_prod[63:32]);
        i_r    <= 4'd2;
      end
      EX_MUL:  t_r <= t_prod[63:32];
      EX_RCP:  prod_r <= 65'(t_r) * 65'(smx_recip(i_r));
      EX_FIX: begin
        term_r <= q_fix;
        sum_r  <= sum_r + 34'(q_fix);
        i_r    <= i_r + 4'd1;
      end
      EX_OUT:  result_r <= (|shifted[34:32]) ? {EXP_W{1'b1}} : shifted[31:0];
      EX_DONE: ;
      default: ;
    endcase
  end

endmodule

### rtl/core/smx_div.sv
// Restoring divider: truncated Q0.16 quotient, saturated at the largest code.
module smx_div
  import smx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [48:0]           dividend,
  input  logic [SUM_W-1:0]      divisor,
  output logic                  done,
  output logic [PROB_W-1:0]     quotient
);

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [SUM_W-1:0]  rem_r;
  logic [15:0]       low_r;
  logic [PROB_W-1:0] quo_r;

  logic [SUM_W:0]    trial;
  logic              qbit;
  logic              sat;

  // One quotient bit per cycle while busy
  always_comb begin
    trial = {rem_r, low_r[15]};
    qbit  = (trial >= {1'b0, divisor});
    sat   = (divisor == '0) || ({5'd0, dividend[48:16]} >= divisor);
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !sat;
        done_r <= sat;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SUM_W'(dividend[48:16]);
      low_r <= dividend[15:0];
      quo_r <= sat ? {PROB_W{1'b1}} : '0;
    end else if (busy_r) begin
      rem_r <= qbit ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
      low_r <= {low_r[14:0], 1'b0};
      quo_r <= {quo_r[PROB_W-2:0], qbit};
    end
  end

endmodule

### tb/sv/softmax_row_normalizer_tb.sv
// Self-checking testbench for the softmax row normalizer.
`timescale 1ns / 1ps

module softmax_row_normalizer_tb
  import smx_pkg::*;
();

  localparam int ROW_CAP = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 140;
  localparam int QUIET_AFTER = 110;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              last_of_row;
    logic              row_overflow;
  } prob_item_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   cycle_count;
  bit   quiet;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  softmax_row_normalizer #(.MAX_ROW(ROW_CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Print one mismatch line and count it
  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Row model: exponentials, running sum and the queue of pending probabilities
  class softmax_scoreboard;
    logic [EXP_W-1:0] row_exps [ROW_CAP];
    logic [SUM_W-1:0] row_sum;
    int               row_len;
    bit               row_dropped;
    prob_item_t       pending_probs [$];

    function new();
      row_sum = '0;
      row_len = 0;
      row_dropped = 0;
    endfunction

    // Exponential of a Q4.12 logit as Q12.20
    function logic [EXP_W-1:0] exp_q12_20(logic signed [LOGIT_W-1:0] x);
      longint          prod;
      longint unsigned q, frac, u, acc, term, r;
      int unsigned     whole, sh;
      prod = longint'(x) * longint'(LOG2E_Q28) + (longint'(12) << 40);
      q = prod;
      whole = int'(q >> 40);
      frac = (q & 64'h00FF_FFFF_FFFF) >> 8;
      u = (frac * longint'(LN2_Q32)) >> 32;
      acc = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int i = 1; i <= 11; i++) begin
        term = ((term * u) >> 32) / i;
        acc += term;
      end
      sh = 24 - whole;
      r = (acc + (64'd1 << (sh - 1))) >> sh;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      return r[EXP_W-1:0];
    endfunction

    // Note an accepted logit; on row end queue every probability
    function void note_logit(logic signed [LOGIT_W-1:0] x, logic row_end);
      longint unsigned sum64, p;
      prob_item_t      item;
      if (row_len < ROW_CAP) begin
        row_exps[row_len] = exp_q12_20(x);
        row_sum = row_sum + row_exps[row_len];
        row_len++;
      end else begin
        row_dropped = 1;
      end
      if (!row_end) return;
      sum64 = row_sum;
      for (int k = 0; k < row_len; k++) begin
        if (sum64 == 0) begin
          p = 65535;
        end else begin
          p = ((longint'(row_exps[k]) << 16) + (sum64 >> 1)) / sum64;
          if (p > 65535) p = 65535;
        end
        item.probability = p[PROB_W-1:0];
        item.last_of_row = (k == row_len - 1);
        item.row_overflow = row_dropped;
        pending_probs.push_back(item);
      end
      row_sum = '0;
      row_len = 0;
      row_dropped = 0;
    endfunction

    // Compare one accepted probability with the oldest pending one
    task check_result(prob_item_t got);
      prob_item_t want;
      if (pending_probs.size() == 0) begin
        report($sformatf("unexpected probability %0d", got.probability));
        return;
      end
      want = pending_probs.pop_front();
      if (got.probability !== want.probability)
        report($sformatf("probability %0d, want %0d", got.probability, want.probability));
      if (got.last_of_row !== want.last_of_row)
        report($sformatf("last_of_row %0b, want %0b", got.last_of_row, want.last_of_row));
      if (got.row_overflow !== want.row_overflow)
        report($sformatf("row_overflow %0b, want %0b", got.row_overflow, want.row_overflow));
    endtask
  endclass

  softmax_scoreboard sb = new();

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("softmax_row_normalizer regression: fail");
      $finish;
    end
  end

  // Check every accepted probability transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.probability, out_ch.last_of_row, out_ch.row_overflow});
  end

  // Output back-pressure in random bursts, none once quiet is set
  initial begin
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Send one logit transaction, with an optional idle burst ahead of it
  task automatic send_logit(input logic signed [LOGIT_W-1:0] x, input logic row_end);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.logit_value <= x;
    in_ch.row_end <= row_end;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_logit(x, row_end);
  endtask

  // Send a row of random logits, about half of them in a moderate range
  task automatic send_random_row(input int len);
    logic signed [LOGIT_W-1:0] x;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1)) x = LOGIT_W'($urandom);
      else x = LOGIT_W'(int'($urandom_range(0, 16383)) - 8192);
      send_logit(x, i == len - 1);
    end
  endtask

  // Stimulus
  initial begin
    int sent;
    int len;
    mismatches = 0;
    cycle_count = 0;
    quiet = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.logit_value = '0;
    in_ch.row_end = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Field extremes, single-item rows and mixed bit patterns
    send_logit(16'sh7FFF, 1);
    send_logit(-16'sh8000, 1);
    send_logit(16'sh0000, 1);
    send_logit(16'sh0000, 0);
    send_logit(16'sh1000, 0);
    send_logit(-16'sh1000, 0);
    send_logit(16'sh7FFF, 0);
    send_logit(-16'sh8000, 1);
    send_logit(16'sh5555, 0);
    send_logit(-16'sh5556, 1);

    // Full row with dropped items, the row end among the dropped ones
    for (int i = 0; i < ROW_CAP; i++) send_logit(LOGIT_W'(i * 97 - 3000), 0);
    send_logit(16'sh0100, 0);
    send_logit(16'sh0200, 1);
    // Row that ends exactly at capacity
    send_random_row(ROW_CAP);

    // Random rows, mostly short, some past capacity
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) len = $urandom_range(60, 70);
      else len = $urandom_range(1, 8);
      if (sent + len > QUIET_AFTER) quiet = 1;
      send_random_row(len);
      sent += len;
    end
    in_ch.valid <= 0;

    // Drain pending probabilities, then allow for a trailing dropped item
    while (sb.pending_probs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("softmax_row_normalizer regression: pass");
    end else begin
      $display("softmax_row_normalizer regression: fail");
    end
    $finish;
  end

endmodule
